>>> sv/cfbd_pkg.sv
`timescale 1ns / 1ps

package cfbd_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [3:0] MAX_PAYLOAD_BYTES = 4'd8;
	localparam logic [3:0] FIRST_PAYLOAD_POS = 4'd6;
	localparam logic [3:0] LENGTH_POS = 4'd5;
	localparam logic [3:0] LAST_ID_POS = 4'd4;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_HDR   = 2'd1,
		STATUS_BAD_LEN   = 2'd2,
		STATUS_BAD_CSUM  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		KIND_HDR_OK  = 3'd0,
		KIND_HDR_BAD = 3'd1,
		KIND_ID      = 3'd2,
		KIND_LEN_OK  = 3'd3,
		KIND_LEN_BAD = 3'd4,
		KIND_DATA    = 3'd5,
		KIND_CSUM    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] idx;
		logic [7:0] data;
	} tok_t;

endpackage

>>> sv/cfbd_front.sv
`timescale 1ns / 1ps

module cfbd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	output logic             rx_ready,
	input  logic [7:0]       rx_byte,
	output logic             tok_valid,
	input  logic             tok_ready,
	output cfbd_pkg::tok_t   tok
);

	logic [3:0] pos_q;
	logic [3:0] len_q;
	logic [3:0] pos_d;
	logic [3:0] len_d;
	logic [3:0] rel;
	logic       accept;

	assign rx_ready  = tok_ready;
	assign tok_valid = rx_valid;
	assign accept    = rx_valid && tok_ready;
	assign rel       = pos_q - cfbd_pkg::FIRST_PAYLOAD_POS;

	always_comb begin
		pos_d     = pos_q;
		len_d     = len_q;
		tok.data  = rx_byte;
		tok.idx   = 3'd0;
		tok.kind  = cfbd_pkg::KIND_CSUM;
		if (pos_q == 4'd0) begin
			if (rx_byte == cfbd_pkg::HEADER_BYTE) begin
				tok.kind = cfbd_pkg::KIND_HDR_OK;
				pos_d    = 4'd1;
			end else begin
				tok.kind = cfbd_pkg::KIND_HDR_BAD;
				pos_d    = 4'd0;
			end
		end else if (pos_q <= cfbd_pkg::LAST_ID_POS) begin
			tok.kind = cfbd_pkg::KIND_ID;
			tok.idx  = 3'(pos_q - 4'd1);
			pos_d    = pos_q + 4'd1;
		end else if (pos_q == cfbd_pkg::LENGTH_POS) begin
			if (rx_byte > {4'd0, cfbd_pkg::MAX_PAYLOAD_BYTES}) begin
				tok.kind = cfbd_pkg::KIND_LEN_BAD;
				pos_d    = 4'd0;
			end else begin
				tok.kind = cfbd_pkg::KIND_LEN_OK;
				len_d    = rx_byte[3:0];
				pos_d    = cfbd_pkg::FIRST_PAYLOAD_POS;
			end
		end else if (rel < len_q) begin
			tok.kind = cfbd_pkg::KIND_DATA;
			tok.idx  = rel[2:0];
			pos_d    = pos_q + 4'd1;
		end else begin
			tok.kind = cfbd_pkg::KIND_CSUM;
			pos_d    = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			len_q <= 4'd0;
		end else if (accept) begin
			pos_q <= pos_d;
			len_q <= len_d;
		end
	end

endmodule

>>> sv/cfbd_queue.sv
`timescale 1ns / 1ps

module cfbd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  cfbd_pkg::tok_t   push_tok,
	output logic             pop_valid,
	input  logic             pop_ready,
	output cfbd_pkg::tok_t   pop_tok
);

	cfbd_pkg::tok_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_tok    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/cfbd_back.sv
`timescale 1ns / 1ps

module cfbd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	output logic             tok_ready,
	input  cfbd_pkg::tok_t   tok,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [1:0]       status,
	output logic [31:0]      can_id,
	output logic [3:0]       data_length,
	output logic [63:0]      payload
);

	logic [31:0] id_q;
	logic [3:0]  len_q;
	logic [63:0] pay_q;
	logic [7:0]  sum_q;
	logic        res_valid_q;
	logic [1:0]  status_q;
	logic [31:0] can_id_q;
	logic [3:0]  data_length_q;
	logic [63:0] payload_q;

	logic        take;
	logic        emit;
	logic [7:0]  sum_add;
	logic [1:0]  status_d;
	logic [31:0] can_id_d;
	logic [3:0]  data_length_d;
	logic [63:0] payload_d;

	assign take      = tok_valid && (!res_valid_q || res_ready);
	assign tok_ready = take;
	assign sum_add   = sum_q + tok.data;

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign can_id      = can_id_q;
	assign data_length = data_length_q;
	assign payload     = payload_q;

	always_comb begin
		emit          = 1'b0;
		status_d      = cfbd_pkg::STATUS_OK;
		can_id_d      = 32'd0;
		data_length_d = 4'd0;
		payload_d     = 64'd0;
		case (tok.kind)
			cfbd_pkg::KIND_HDR_BAD: begin
				emit     = 1'b1;
				status_d = cfbd_pkg::STATUS_BAD_HDR;
			end
			cfbd_pkg::KIND_LEN_BAD: begin
				emit     = 1'b1;
				status_d = cfbd_pkg::STATUS_BAD_LEN;
			end
			cfbd_pkg::KIND_CSUM: begin
				emit = 1'b1;
				if (tok.data != sum_q) begin
					status_d = cfbd_pkg::STATUS_BAD_CSUM;
				end else begin
					status_d      = cfbd_pkg::STATUS_OK;
					can_id_d      = id_q;
					data_length_d = len_q;
					payload_d     = pay_q;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (tok.kind)
				cfbd_pkg::KIND_HDR_OK: begin
					id_q  <= 32'd0;
					pay_q <= 64'd0;
					len_q <= 4'd0;
					sum_q <= tok.data;
				end
				cfbd_pkg::KIND_ID: begin
					id_q  <= id_q | ({24'd0, tok.data} << {tok.idx[1:0], 3'b000});
					sum_q <= sum_add;
				end
				cfbd_pkg::KIND_LEN_OK: begin
					len_q <= tok.data[3:0];
					sum_q <= sum_add;
				end
				cfbd_pkg::KIND_DATA: begin
					pay_q <= pay_q | ({56'd0, tok.data} << {tok.idx, 3'b000});
					sum_q <= sum_add;
				end
				default: begin
					sum_q <= sum_q;
				end
			endcase
		end
		if (take && emit) begin
			status_q      <= status_d;
			can_id_q      <= can_id_d;
			data_length_q <= data_length_d;
			payload_q     <= payload_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/can_frame_byte_deframer_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// rx        rx_valid / rx_ready   rx_byte[7:0]
// res       res_valid / res_ready status[1:0], can_id[31:0], data_length[3:0], payload[63:0]
//
// One byte transfer is accepted per cycle while the two-entry queue has room.
// A frame-ending or error byte goes through the queue, then the back registers its result.
// The front tracks the byte position, the back updates the accumulators and the
// checksum, and the queue between them absorbs a stall on the result side.
// Reset returns the block to hunting for a header and empties the queue.

module can_frame_byte_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  status,
	output logic [31:0] can_id,
	output logic [3:0]  data_length,
	output logic [63:0] payload
);

	logic           f_valid;
	logic           f_ready;
	cfbd_pkg::tok_t f_tok;
	logic           b_valid;
	logic           b_ready;
	cfbd_pkg::tok_t b_tok;

	cfbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	cfbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_tok   (f_tok),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_tok    (b_tok)
	);

	cfbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (b_valid),
		.tok_ready   (b_ready),
		.tok         (b_tok),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.can_id      (can_id),
		.data_length (data_length),
		.payload     (payload)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int BYTE_COUNT = 1300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		cfbd_pkg::status_t st;
		logic [31:0]       id;
		logic [3:0]        len;
		logic [63:0]       data;
	} frame_result_t;

	class deframer_scoreboard;
		logic [3:0]    pos;
		logic [31:0]   id_acc;
		logic [3:0]    len_held;
		logic [63:0]   data_acc;
		logic [7:0]    sum;
		frame_result_t expected_frames[$];
		int            mismatches;

		function new();
			clear_frame();
			mismatches = 0;
		endfunction

		function void clear_frame();
			pos = 4'd0;
			id_acc = '0;
			len_held = '0;
			data_acc = '0;
			sum = '0;
		endfunction

		function void push_result(cfbd_pkg::status_t st, logic [31:0] id, logic [3:0] len,
				logic [63:0] data);
			frame_result_t r;
			r.st = st;
			r.id = id;
			r.len = len;
			r.data = data;
			expected_frames.push_back(r);
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function void take_byte(logic [7:0] b);
			int k;
			if (pos == 4'd0) begin
				if (b != cfbd_pkg::HEADER_BYTE) begin
					clear_frame();
					push_result(cfbd_pkg::STATUS_BAD_HDR, '0, '0, '0);
				end else begin
					sum = b;
					pos = 4'd1;
				end
			end else if (pos <= cfbd_pkg::LAST_ID_POS) begin
				id_acc |= 32'(b) << (8 * (int'(pos) - 1));
				sum = sum + b;
				pos = pos + 4'd1;
			end else if (pos == cfbd_pkg::LENGTH_POS) begin
				if (b > 8'(cfbd_pkg::MAX_PAYLOAD_BYTES)) begin
					clear_frame();
					push_result(cfbd_pkg::STATUS_BAD_LEN, '0, '0, '0);
				end else begin
					len_held = b[3:0];
					sum = sum + b;
					pos = cfbd_pkg::FIRST_PAYLOAD_POS;
				end
			end else if (int'(pos) - int'(cfbd_pkg::FIRST_PAYLOAD_POS) < int'(len_held)) begin
				k = (int'(pos) - int'(cfbd_pkg::FIRST_PAYLOAD_POS)) & 7;
				data_acc |= 64'(b) << (8 * k);
				sum = sum + b;
				pos = pos + 4'd1;
			end else if (b != sum) begin
				clear_frame();
				push_result(cfbd_pkg::STATUS_BAD_CSUM, '0, '0, '0);
			end else begin
				push_result(cfbd_pkg::STATUS_OK, id_acc, len_held, data_acc);
				clear_frame();
			end
		endfunction

		function void compare_result(logic [1:0] st, logic [31:0] id, logic [3:0] len,
				logic [63:0] data);
			frame_result_t e;
			if (expected_frames.size() == 0) begin
				flag($sformatf("Unexpected result: status %0d id %h length %0d payload %h",
					st, id, len, data));
				return;
			end
			e = expected_frames.pop_front();
			if (st != e.st || id != e.id || len != e.len || data != e.data) begin
				flag($sformatf({"Mismatch: status exp %0d got %0d, id exp %h got %h, ",
					"length exp %0d got %0d, payload exp %h got %h"},
					e.st, st, e.id, id, e.len, len, e.data, data));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] can_id;
	logic [3:0]  data_length;
	logic [63:0] payload;

	deframer_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_sent = 0;
	int cycles = 0;

	can_frame_byte_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status(status),
		.can_id(can_id),
		.data_length(data_length),
		.payload(payload)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			sb.compare_result(status, can_id, data_length, payload);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic drive_frame(input logic [31:0] id, input logic [7:0] len_byte,
			input logic [63:0] data, input logic [7:0] csum_flip);
		logic [7:0] acc;
		int i;
		acc = cfbd_pkg::HEADER_BYTE;
		send_byte(cfbd_pkg::HEADER_BYTE);
		for (i = 0; i < 4; i++) begin
			send_byte(id[8*i +: 8]);
			acc = acc + id[8*i +: 8];
		end
		send_byte(len_byte);
		acc = acc + len_byte;
		if (len_byte > 8'(cfbd_pkg::MAX_PAYLOAD_BYTES)) begin
			return;
		end
		for (i = 0; i < int'(len_byte); i++) begin
			send_byte(data[8*i +: 8]);
			acc = acc + data[8*i +: 8];
		end
		send_byte(acc ^ csum_flip);
	endtask

	task automatic wait_for_results();
		rx_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic send_random_unit();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			drive_frame($urandom, 8'($urandom_range(8)), {$urandom, $urandom}, 8'h00);
		end else if (r < 80) begin
			drive_frame($urandom, 8'($urandom_range(8)), {$urandom, $urandom},
				8'($urandom_range(255, 1)));
		end else if (r < 88) begin
			drive_frame($urandom, 8'($urandom_range(255, 9)), '0, 8'h00);
		end else begin
			send_byte(8'($urandom));
		end
	endtask

	initial begin
		int phase;
		int want;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		phase = 0;
		send_idle_pct = 8;
		recv_stall_pct = 75;

		send_byte(8'h00);
		send_byte(8'hFF);
		drive_frame(32'hFFFF_FFFF, 8'd0, '0, 8'h00);
		drive_frame(32'h0000_0000, 8'hFF, '0, 8'h00);
		drive_frame(32'h1234_5678, 8'd1, 64'h55, 8'h01);
		wait_for_results();

		while (bytes_sent < BYTE_COUNT) begin
			want = (bytes_sent < BYTE_COUNT / 3) ? 0 :
				(bytes_sent < 2 * BYTE_COUNT / 3) ? 1 : 2;
			if (want != phase) begin
				wait_for_results();
				phase = want;
				send_idle_pct = (phase == 1) ? 75 : 0;
				recv_stall_pct = (phase == 1) ? 8 : 0;
			end
			send_random_unit();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> can_frame_byte_deframer_unit.f
sv/cfbd_pkg.sv
sv/cfbd_front.sv
sv/cfbd_queue.sv
sv/cfbd_back.sv
sv/can_frame_byte_deframer_unit.sv
sim/tb_top.sv
